>>> rtl/ievhid_pkg.sv
package ievhid_pkg;

    // Event fields
    localparam logic       OP_EVENT = 1'b0;
    localparam logic       OP_TICK  = 1'b1;
    localparam logic [4:0] KIND_KEY = 5'd1;
    localparam logic [4:0] KIND_REL = 5'd2;

    localparam logic [9:0] CODE_BTN_LEFT   = 10'h110;
    localparam logic [9:0] CODE_BTN_MIDDLE = 10'h112;
    localparam logic [9:0] CODE_REL_X      = 10'd0;
    localparam logic [9:0] CODE_REL_Y      = 10'd1;
    localparam logic [9:0] CODE_REL_WHEEL  = 10'd8;

    // Report ids
    localparam logic [1:0] REPORT_MOUSE = 2'd1;
    localparam logic [1:0] REPORT_KBD   = 2'd2;

    // Axis selection and shared unit modes
    localparam logic [1:0] AXIS_X     = 2'd0;
    localparam logic [1:0] AXIS_Y     = 2'd1;
    localparam logic [1:0] AXIS_WHEEL = 2'd2;
    localparam logic       AXIS_ADD   = 1'b0;
    localparam logic       AXIS_DRAIN = 1'b1;

    localparam int ACC_W      = 14;
    localparam int STEP_W     = 8;
    localparam int USAGE_W    = 7;
    localparam int ACC_LIMIT  = 8128;
    localparam int STEP_LIMIT = 127;

    typedef struct packed {
        logic       hit;
        logic [2:0] bit_idx;
    } mod_sel_t;

    // Key code to usage, codes 0..127
    localparam logic [USAGE_W-1:0] USAGE_TABLE [128] = '{
        7'd0,  7'd41, 7'd30, 7'd31, 7'd32, 7'd33, 7'd34, 7'd35,
        7'd36, 7'd37, 7'd38, 7'd39, 7'd45, 7'd46, 7'd42, 7'd43,
        7'd20, 7'd26, 7'd8,  7'd21, 7'd23, 7'd28, 7'd24, 7'd12,
        7'd18, 7'd19, 7'd47, 7'd48, 7'd40, 7'd0,  7'd4,  7'd22,
        7'd7,  7'd9,  7'd10, 7'd11, 7'd13, 7'd14, 7'd15, 7'd51,
        7'd52, 7'd53, 7'd0,  7'd49, 7'd29, 7'd27, 7'd6,  7'd25,
        7'd5,  7'd17, 7'd16, 7'd54, 7'd55, 7'd56, 7'd0,  7'd85,
        7'd0,  7'd44, 7'd57, 7'd58, 7'd59, 7'd60, 7'd61, 7'd62,
        7'd63, 7'd64, 7'd65, 7'd66, 7'd67, 7'd83, 7'd71, 7'd95,
        7'd96, 7'd97, 7'd86, 7'd92, 7'd93, 7'd94, 7'd87, 7'd89,
        7'd90, 7'd91, 7'd98, 7'd99, 7'd0,  7'd0,  7'd0,  7'd68,
        7'd69, 7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,
        7'd88, 7'd0,  7'd84, 7'd70, 7'd0,  7'd0,  7'd74, 7'd82,
        7'd75, 7'd80, 7'd79, 7'd77, 7'd81, 7'd78, 7'd73, 7'd76,
        7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd72,
        7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0
    };

    function automatic logic [USAGE_W-1:0] key_usage(input logic [9:0] code);
        logic [USAGE_W-1:0] u;
        u = 7'd0;
        if (code[9:7] == 3'd0)
        begin
            u = USAGE_TABLE[code[6:0]];
        end
        return u;
    endfunction

    function automatic mod_sel_t modifier_sel(input logic [9:0] code);
        mod_sel_t s;
        s.hit     = 1'b1;
        s.bit_idx = 3'd0;
        case (code)
            10'd29:  s.bit_idx = 3'd0;
            10'd42:  s.bit_idx = 3'd1;
            10'd56:  s.bit_idx = 3'd2;
            10'd125: s.bit_idx = 3'd3;
            10'd97:  s.bit_idx = 3'd4;
            10'd54:  s.bit_idx = 3'd5;
            10'd100: s.bit_idx = 3'd6;
            10'd126: s.bit_idx = 3'd7;
            default: s.hit     = 1'b0;
        endcase
        return s;
    endfunction

endpackage

>>> rtl/ievhid_axis_unit.sv
// Shared axis arithmetic: saturating accumulate or clamp-and-drain step.
module ievhid_axis_unit
    import ievhid_pkg::*;
(
    input  logic                     mode,
    input  logic signed [ACC_W-1:0]  acc,
    input  logic signed [31:0]       delta,
    output logic signed [ACC_W-1:0]  acc_next,
    output logic signed [STEP_W-1:0] step
);

    localparam int SUM_W = 34;

    logic signed [SUM_W-1:0] sum;
    logic signed [ACC_W-1:0] sat;
    logic signed [ACC_W-1:0] step_wide;

    assign sum = SUM_W'(acc) + SUM_W'(delta);

    always_comb
    begin
        if (sum > SUM_W'(ACC_LIMIT))
        begin
            sat = ACC_W'(ACC_LIMIT);
        end
        else if (sum < -SUM_W'(ACC_LIMIT))
        begin
            sat = -ACC_W'(ACC_LIMIT);
        end
        else
        begin
            sat = sum[ACC_W-1:0];
        end

        if (acc > ACC_W'(STEP_LIMIT))
        begin
            step_wide = ACC_W'(STEP_LIMIT);
        end
        else if (acc < -ACC_W'(STEP_LIMIT))
        begin
            step_wide = -ACC_W'(STEP_LIMIT);
        end
        else
        begin
            step_wide = acc;
        end
    end

    assign acc_next = (mode == AXIS_DRAIN) ? (acc - step_wide) : sat;
    assign step     = step_wide[STEP_W-1:0];

endmodule

>>> rtl/input_event_to_hid_report.sv
// Motion event: added to its accumulator by the shared unit; no report. Button or modifier
// event: one report. A key press or release with a usage first scans the pressed list, one
// slot compared per cycle. Tick: 3 axis steps through the shared unit and 1 emit per mouse
// report, up to MAX_REPORTS_PER_TICK reports. One item in flight; event_stall is high meanwhile.
// Reset: async active-low; pressed list, modifiers, buttons and accumulators clear to zero.
module input_event_to_hid_report
    import ievhid_pkg::*;
#(
    parameter int KEY_SLOT_COUNT       = 8,
    parameter int MAX_REPORTS_PER_TICK = 64
)
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               event_valid,
    output logic               event_stall,
    input  logic               operation,
    input  logic [4:0]         event_kind,
    input  logic [9:0]         event_code,
    input  logic signed [31:0] event_value,

    output logic               report_valid,
    input  logic               report_stall,
    output logic [1:0]         report_id,
    output logic [2:0]         button_mask,
    output logic signed [7:0]  move_x,
    output logic signed [7:0]  move_y,
    output logic signed [7:0]  move_wheel,
    output logic [7:0]         modifier_mask,
    output logic [63:0]        key_slots,
    output logic               last
);

    localparam int IDX_W = (KEY_SLOT_COUNT > 1) ? $clog2(KEY_SLOT_COUNT) : 1;
    localparam int CNT_W = $clog2(MAX_REPORTS_PER_TICK + 1);

    // Sequencer states
    localparam logic [2:0] S_IDLE       = 3'd0;
    localparam logic [2:0] S_DECODE     = 3'd1;
    localparam logic [2:0] S_ADD        = 3'd2;
    localparam logic [2:0] S_SCAN       = 3'd3;
    localparam logic [2:0] S_STEP       = 3'd4;
    localparam logic [2:0] S_EMIT_MOUSE = 3'd5;
    localparam logic [2:0] S_EMIT_KEY   = 3'd6;

    logic [2:0] state_reg, state_next;

    // Captured item
    logic               op_reg,    op_next;
    logic [4:0]         kind_reg,  kind_next;
    logic [9:0]         code_reg,  code_next;
    logic signed [31:0] value_reg, value_next;

    // Working registers
    logic [USAGE_W-1:0] usage_reg,  usage_next;
    logic               remove_reg, remove_next;
    logic [IDX_W-1:0]   idx_reg,    idx_next;
    logic [1:0]         axis_reg,   axis_next;
    logic [CNT_W-1:0]   n_reg,      n_next;
    logic signed [STEP_W-1:0] step_x_reg, step_x_next;
    logic signed [STEP_W-1:0] step_y_reg, step_y_next;
    logic signed [STEP_W-1:0] step_w_reg, step_w_next;

    // Architectural state
    logic [2:0]              button_reg,   button_next;
    logic [7:0]              modifier_reg, modifier_next;
    logic [USAGE_W-1:0]      list_reg [KEY_SLOT_COUNT];
    logic [USAGE_W-1:0]      list_next [KEY_SLOT_COUNT];
    logic signed [ACC_W-1:0] acc_x_reg, acc_x_next;
    logic signed [ACC_W-1:0] acc_y_reg, acc_y_next;
    logic signed [ACC_W-1:0] acc_w_reg, acc_w_next;

    // Output register
    logic               rpt_valid_reg,  rpt_valid_next;
    logic [1:0]         rpt_id_reg,     rpt_id_next;
    logic [2:0]         rpt_button_reg, rpt_button_next;
    logic signed [7:0]  rpt_x_reg,      rpt_x_next;
    logic signed [7:0]  rpt_y_reg,      rpt_y_next;
    logic signed [7:0]  rpt_w_reg,      rpt_w_next;
    logic [7:0]         rpt_mod_reg,    rpt_mod_next;
    logic [63:0]        rpt_keys_reg,   rpt_keys_next;
    logic               rpt_last_reg,   rpt_last_next;

    // Shared unit hookup
    logic                     unit_mode;
    logic signed [ACC_W-1:0]  unit_acc;
    logic signed [ACC_W-1:0]  unit_acc_next;
    logic signed [STEP_W-1:0] unit_step;

    logic        in_xfer;
    logic        out_free;
    logic        acc_zero;
    logic        mouse_last;
    logic        slot_hit;
    logic [63:0] slots_packed;
    logic [2:0]  btn_bit;
    mod_sel_t    mod_sel;

    assign in_xfer     = event_valid && !event_stall;
    assign event_stall = (state_reg != S_IDLE);
    assign out_free    = !rpt_valid_reg || !report_stall;
    assign acc_zero    = (acc_x_reg == '0) && (acc_y_reg == '0) && (acc_w_reg == '0);
    // Tick run ends when all axes drained or the per-tick cap is hit.
    assign mouse_last  = (op_reg != OP_TICK) || acc_zero
                         || (n_reg == CNT_W'(MAX_REPORTS_PER_TICK - 1));
    assign mod_sel     = modifier_sel(code_reg);
    assign btn_bit     = 3'b001 << code_reg[1:0];

    // One comparator walks the list: find a free slot, or the matching usage.
    assign slot_hit = (list_reg[idx_reg] == (remove_reg ? usage_reg : USAGE_W'(0)));

    always_comb
    begin
        slots_packed = '0;
        for (int i = 0; i < KEY_SLOT_COUNT; i++)
        begin
            slots_packed[8*i +: 8] = {1'b0, list_reg[i]};
        end
    end

    always_comb
    begin
        case (axis_reg)
            AXIS_X:     unit_acc = acc_x_reg;
            AXIS_Y:     unit_acc = acc_y_reg;
            AXIS_WHEEL: unit_acc = acc_w_reg;
            default:    unit_acc = acc_x_reg;
        endcase
    end

    assign unit_mode = (state_reg == S_ADD) ? AXIS_ADD : AXIS_DRAIN;

    ievhid_axis_unit u_axis (
        .mode     (unit_mode),
        .acc      (unit_acc),
        .delta    (value_reg),
        .acc_next (unit_acc_next),
        .step     (unit_step)
    );

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        kind_next     = kind_reg;
        code_next     = code_reg;
        value_next    = value_reg;
        usage_next    = usage_reg;
        remove_next   = remove_reg;
        idx_next      = idx_reg;
        axis_next     = axis_reg;
        n_next        = n_reg;
        step_x_next   = step_x_reg;
        step_y_next   = step_y_reg;
        step_w_next   = step_w_reg;
        button_next   = button_reg;
        modifier_next = modifier_reg;
        list_next     = list_reg;
        acc_x_next    = acc_x_reg;
        acc_y_next    = acc_y_reg;
        acc_w_next    = acc_w_reg;

        // Output slot empties on transfer unless reloaded below.
        rpt_valid_next  = rpt_valid_reg && report_stall;
        rpt_id_next     = rpt_id_reg;
        rpt_button_next = rpt_button_reg;
        rpt_x_next      = rpt_x_reg;
        rpt_y_next      = rpt_y_reg;
        rpt_w_next      = rpt_w_reg;
        rpt_mod_next    = rpt_mod_reg;
        rpt_keys_next   = rpt_keys_reg;
        rpt_last_next   = rpt_last_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    op_next    = operation;
                    kind_next  = event_kind;
                    code_next  = event_code;
                    value_next = event_value;
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                idx_next    = '0;
                n_next      = '0;
                axis_next   = AXIS_X;
                usage_next  = key_usage(code_reg);
                remove_next = (value_reg == 32'sd0);
                state_next  = S_IDLE;
                if (op_reg == OP_TICK)
                begin
                    if (!acc_zero)
                    begin
                        state_next = S_STEP;
                    end
                end
                else if (kind_reg == KIND_REL)
                begin
                    if (code_reg == CODE_REL_X)
                    begin
                        axis_next  = AXIS_X;
                        state_next = S_ADD;
                    end
                    else if (code_reg == CODE_REL_Y)
                    begin
                        axis_next  = AXIS_Y;
                        state_next = S_ADD;
                    end
                    else if (code_reg == CODE_REL_WHEEL)
                    begin
                        axis_next  = AXIS_WHEEL;
                        state_next = S_ADD;
                    end
                end
                else if (kind_reg == KIND_KEY)
                begin
                    if ((code_reg >= CODE_BTN_LEFT) && (code_reg <= CODE_BTN_MIDDLE))
                    begin
                        // Only a press sets; release and repeat clear.
                        button_next = (button_reg & ~btn_bit)
                                      | ((value_reg == 32'sd1) ? btn_bit : 3'b000);
                        step_x_next = '0;
                        step_y_next = '0;
                        step_w_next = '0;
                        state_next  = S_EMIT_MOUSE;
                    end
                    else if (mod_sel.hit)
                    begin
                        modifier_next = modifier_reg & ~(8'd1 << mod_sel.bit_idx);
                        if (!value_reg[31] && (value_reg != 32'sd0))
                        begin
                            modifier_next = modifier_next | (8'd1 << mod_sel.bit_idx);
                        end
                        state_next = S_EMIT_KEY;
                    end
                    else if ((usage_next != '0)
                             && ((value_reg == 32'sd1) || (value_reg == 32'sd0)))
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_EMIT_KEY;
                    end
                end
            end

            S_ADD:
            begin
                case (axis_reg)
                    AXIS_X:     acc_x_next = unit_acc_next;
                    AXIS_Y:     acc_y_next = unit_acc_next;
                    AXIS_WHEEL: acc_w_next = unit_acc_next;
                    default:    acc_x_next = acc_x_reg;
                endcase
                state_next = S_IDLE;
            end

            S_SCAN:
            begin
                if (slot_hit)
                begin
                    if (remove_reg)
                    begin
                        // Close the gap: every slot from the hit onward pulls from above.
                        for (int j = 0; j < KEY_SLOT_COUNT - 1; j++)
                        begin
                            if (IDX_W'(j) >= idx_reg)
                            begin
                                list_next[j] = list_reg[j+1];
                            end
                        end
                        list_next[KEY_SLOT_COUNT-1] = '0;
                    end
                    else
                    begin
                        list_next[idx_reg] = usage_reg;
                    end
                    state_next = S_EMIT_KEY;
                end
                else if (idx_reg == IDX_W'(KEY_SLOT_COUNT - 1))
                begin
                    state_next = S_EMIT_KEY;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            S_STEP:
            begin
                case (axis_reg)
                    AXIS_X:
                    begin
                        acc_x_next  = unit_acc_next;
                        step_x_next = unit_step;
                        axis_next   = AXIS_Y;
                    end
                    AXIS_Y:
                    begin
                        acc_y_next  = unit_acc_next;
                        step_y_next = unit_step;
                        axis_next   = AXIS_WHEEL;
                    end
                    default:
                    begin
                        acc_w_next  = unit_acc_next;
                        step_w_next = unit_step;
                        axis_next   = AXIS_X;
                        state_next  = S_EMIT_MOUSE;
                    end
                endcase
            end

            S_EMIT_MOUSE:
            begin
                if (out_free)
                begin
                    rpt_valid_next  = 1'b1;
                    rpt_id_next     = REPORT_MOUSE;
                    rpt_button_next = button_reg;
                    rpt_x_next      = step_x_reg;
                    rpt_y_next      = step_y_reg;
                    rpt_w_next      = step_w_reg;
                    rpt_mod_next    = '0;
                    rpt_keys_next   = '0;
                    rpt_last_next   = mouse_last;
                    n_next          = n_reg + 1'b1;
                    axis_next       = AXIS_X;
                    state_next      = mouse_last ? S_IDLE : S_STEP;
                end
            end

            S_EMIT_KEY:
            begin
                if (out_free)
                begin
                    rpt_valid_next  = 1'b1;
                    rpt_id_next     = REPORT_KBD;
                    rpt_button_next = '0;
                    rpt_x_next      = '0;
                    rpt_y_next      = '0;
                    rpt_w_next      = '0;
                    rpt_mod_next    = modifier_reg;
                    rpt_keys_next   = slots_packed;
                    rpt_last_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rpt_valid_reg <= 1'b0;
            button_reg    <= '0;
            modifier_reg  <= '0;
            acc_x_reg     <= '0;
            acc_y_reg     <= '0;
            acc_w_reg     <= '0;
            n_reg         <= '0;
            axis_reg      <= AXIS_X;
            idx_reg       <= '0;
            for (int i = 0; i < KEY_SLOT_COUNT; i++)
            begin
                list_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            rpt_valid_reg <= rpt_valid_next;
            button_reg    <= button_next;
            modifier_reg  <= modifier_next;
            acc_x_reg     <= acc_x_next;
            acc_y_reg     <= acc_y_next;
            acc_w_reg     <= acc_w_next;
            n_reg         <= n_next;
            axis_reg      <= axis_next;
            idx_reg       <= idx_next;
            list_reg      <= list_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        kind_reg       <= kind_next;
        code_reg       <= code_next;
        value_reg      <= value_next;
        usage_reg      <= usage_next;
        remove_reg     <= remove_next;
        step_x_reg     <= step_x_next;
        step_y_reg     <= step_y_next;
        step_w_reg     <= step_w_next;
        rpt_id_reg     <= rpt_id_next;
        rpt_button_reg <= rpt_button_next;
        rpt_x_reg      <= rpt_x_next;
        rpt_y_reg      <= rpt_y_next;
        rpt_w_reg      <= rpt_w_next;
        rpt_mod_reg    <= rpt_mod_next;
        rpt_keys_reg   <= rpt_keys_next;
        rpt_last_reg   <= rpt_last_next;
    end

    assign report_valid  = rpt_valid_reg;
    assign report_id     = rpt_id_reg;
    assign button_mask   = rpt_button_reg;
    assign move_x        = rpt_x_reg;
    assign move_y        = rpt_y_reg;
    assign move_wheel    = rpt_w_reg;
    assign modifier_mask = rpt_mod_reg;
    assign key_slots     = rpt_keys_reg;
    assign last          = rpt_last_reg;

    // Accumulators never leave the saturation window.
    a_acc_range: assert property (@(posedge clk) disable iff (!rst_n)
        (acc_x_reg <= 14'sd8128) && (acc_x_reg >= -14'sd8128)
        && (acc_y_reg <= 14'sd8128) && (acc_y_reg >= -14'sd8128)
        && (acc_w_reg <= 14'sd8128) && (acc_w_reg >= -14'sd8128))
        else $error("accumulator outside saturation window");

    // A keyboard report always closes its item.
    a_kbd_last: assert property (@(posedge clk) disable iff (!rst_n)
        (rpt_valid_reg && (rpt_id_reg == REPORT_KBD)) |-> rpt_last_reg)
        else $error("keyboard report without last");

    // Drained steps stay inside the clamp.
    a_step_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        (rpt_valid_reg && (rpt_id_reg == REPORT_MOUSE)) |->
        ((rpt_x_reg != -8'sd128) && (rpt_y_reg != -8'sd128) && (rpt_w_reg != -8'sd128)))
        else $error("mouse step out of clamp range");

    // Tick run never exceeds the per-tick cap.
    a_tick_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_STEP) |-> (n_reg < CNT_W'(MAX_REPORTS_PER_TICK)))
        else $error("tick report count over cap");

    // Busy sequencer takes no new transfer.
    a_busy_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |=> ($stable(op_reg) && $stable(code_reg))
        || ($past(state_reg) == S_IDLE))
        else $error("item registers changed while busy");

endmodule

>>> test/tb_input_event_to_hid_report.sv
module tb_input_event_to_hid_report;
    timeunit 1ns;
    timeprecision 1ps;

    import ievhid_pkg::*;

    localparam int SLOTS             = 8;
    localparam int TICK_REPORT_LIMIT = 64;
    localparam int ACC_SAT           = 8128;
    localparam int STEP_MAX          = 127;
    localparam int TARGET_EVENTS     = 210;
    localparam int TAIL_CYCLES       = 40;

    // Key codes used by the directed part and the modifier decode
    localparam logic [9:0] KEY_1          = 10'd2;
    localparam logic [9:0] KEY_2          = 10'd3;
    localparam logic [9:0] KEY_6          = 10'd7;
    localparam logic [9:0] KEY_0          = 10'd11;
    localparam logic [9:0] KEY_Q          = 10'd16;
    localparam logic [9:0] KEY_A          = 10'd30;
    localparam logic [9:0] KEY_UNMAPPED   = 10'd84;
    localparam logic [9:0] CODE_TOP       = 10'd767;
    localparam logic [9:0] KEY_LCTRL      = 10'd29;
    localparam logic [9:0] KEY_LSHIFT     = 10'd42;
    localparam logic [9:0] KEY_LALT       = 10'd56;
    localparam logic [9:0] KEY_LMETA      = 10'd125;
    localparam logic [9:0] KEY_RCTRL      = 10'd97;
    localparam logic [9:0] KEY_RSHIFT     = 10'd54;
    localparam logic [9:0] KEY_RALT       = 10'd100;
    localparam logic [9:0] KEY_RMETA      = 10'd126;
    localparam logic [9:0] CODE_BTN_RIGHT = 10'h111;
    localparam logic [9:0] CODE_REL_Z     = 10'd2;
    localparam logic [4:0] KIND_NONE      = 5'd0;
    localparam logic [4:0] KIND_TOP       = 5'd31;

    localparam logic [9:0] MOD_KEYS [8] = '{
        KEY_LCTRL, KEY_LSHIFT, KEY_LALT, KEY_LMETA,
        KEY_RCTRL, KEY_RSHIFT, KEY_RALT, KEY_RMETA
    };

    // Linux key code -> HID usage, codes 0..127
    localparam logic [6:0] KEY_TO_USAGE [128] = '{
        7'd0,  7'd41, 7'd30, 7'd31, 7'd32, 7'd33, 7'd34, 7'd35,
        7'd36, 7'd37, 7'd38, 7'd39, 7'd45, 7'd46, 7'd42, 7'd43,
        7'd20, 7'd26, 7'd8,  7'd21, 7'd23, 7'd28, 7'd24, 7'd12,
        7'd18, 7'd19, 7'd47, 7'd48, 7'd40, 7'd0,  7'd4,  7'd22,
        7'd7,  7'd9,  7'd10, 7'd11, 7'd13, 7'd14, 7'd15, 7'd51,
        7'd52, 7'd53, 7'd0,  7'd49, 7'd29, 7'd27, 7'd6,  7'd25,
        7'd5,  7'd17, 7'd16, 7'd54, 7'd55, 7'd56, 7'd0,  7'd85,
        7'd0,  7'd44, 7'd57, 7'd58, 7'd59, 7'd60, 7'd61, 7'd62,
        7'd63, 7'd64, 7'd65, 7'd66, 7'd67, 7'd83, 7'd71, 7'd95,
        7'd96, 7'd97, 7'd86, 7'd92, 7'd93, 7'd94, 7'd87, 7'd89,
        7'd90, 7'd91, 7'd98, 7'd99, 7'd0,  7'd0,  7'd0,  7'd68,
        7'd69, 7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,
        7'd88, 7'd0,  7'd84, 7'd70, 7'd0,  7'd0,  7'd74, 7'd82,
        7'd75, 7'd80, 7'd79, 7'd77, 7'd81, 7'd78, 7'd73, 7'd76,
        7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd72,
        7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0
    };

    typedef struct {
        logic        op;
        logic [4:0]  kind;
        logic [9:0]  code;
        logic [31:0] value;
        bit          hold;      // wait for all outstanding reports before sending
    } input_event_t;

    typedef struct {
        logic [1:0]  id;
        logic [2:0]  buttons;
        logic [7:0]  dx;
        logic [7:0]  dy;
        logic [7:0]  dw;
        logic [7:0]  mods;
        logic [63:0] slots;
        logic        last;
    } hid_report_t;

    // Clock, reset and DUT ports; every input starts at a known value
    logic               clk;
    logic               rst_n         = 1'b0;
    logic               event_valid   = 1'b0;
    logic               event_stall;
    logic               operation     = OP_EVENT;
    logic [4:0]         event_kind    = KIND_NONE;
    logic [9:0]         event_code    = '0;
    logic signed [31:0] event_value   = '0;
    logic               report_valid;
    logic               report_stall  = 1'b0;
    logic [1:0]         report_id;
    logic [2:0]         button_mask;
    logic signed [7:0]  move_x;
    logic signed [7:0]  move_y;
    logic signed [7:0]  move_wheel;
    logic [7:0]         modifier_mask;
    logic [63:0]        key_slots;
    logic               last;

    // Shadow of the generator state
    logic [6:0]  held_keys [SLOTS];
    logic [7:0]  mod_state;
    logic [2:0]  button_state;
    int          acc_x;
    int          acc_y;
    int          acc_wheel;

    input_event_t queued_events [$];
    hid_report_t  pending_reports [$];
    input_event_t in_flight;
    hid_report_t  want_report;
    int           events_accepted = 0;
    int           total_events    = 0;
    int           errors          = 0;

    input_event_to_hid_report #(
        .KEY_SLOT_COUNT       (SLOTS),
        .MAX_REPORTS_PER_TICK (TICK_REPORT_LIMIT)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .event_valid   (event_valid),
        .event_stall   (event_stall),
        .operation     (operation),
        .event_kind    (event_kind),
        .event_code    (event_code),
        .event_value   (event_value),
        .report_valid  (report_valid),
        .report_stall  (report_stall),
        .report_id     (report_id),
        .button_mask   (button_mask),
        .move_x        (move_x),
        .move_y        (move_y),
        .move_wheel    (move_wheel),
        .modifier_mask (modifier_mask),
        .key_slots     (key_slots),
        .last          (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Motion accumulators saturate at +-8128
    function automatic int sat_acc(input int acc, input longint delta);
        longint s;
        s = longint'(acc) + delta;
        if (s > ACC_SAT)
            s = ACC_SAT;
        if (s < -ACC_SAT)
            s = -ACC_SAT;
        return int'(s);
    endfunction

    // Per-report step limit
    function automatic int clamp_step(input int v);
        if (v > STEP_MAX)
            return STEP_MAX;
        if (v < -STEP_MAX)
            return -STEP_MAX;
        return v;
    endfunction

    function automatic int modifier_index(input logic [9:0] code);
        case (code)
            KEY_LCTRL:  return 0;
            KEY_LSHIFT: return 1;
            KEY_LALT:   return 2;
            KEY_LMETA:  return 3;
            KEY_RCTRL:  return 4;
            KEY_RSHIFT: return 5;
            KEY_RALT:   return 6;
            KEY_RMETA:  return 7;
            default:    return -1;
        endcase
    endfunction

    function automatic hid_report_t mouse_report(input int dx, input int dy, input int dw);
        hid_report_t r;
        r.id      = REPORT_MOUSE;
        r.buttons = button_state;
        r.dx      = dx[7:0];
        r.dy      = dy[7:0];
        r.dw      = dw[7:0];
        r.mods    = '0;
        r.slots   = '0;
        r.last    = 1'b1;
        return r;
    endfunction

    // Update the shadow state for one accepted transfer and queue its reports
    task automatic apply_event(input input_event_t ev);
        hid_report_t r;
        longint      v;
        int          n;
        int          sx;
        int          sy;
        int          sw;
        int          idx;
        int          i;
        logic [6:0]  usage;
        bit          done;
        v = longint'($signed(ev.value));
        if (ev.op == OP_TICK)
        begin
            n = 0;
            while (n < TICK_REPORT_LIMIT && (acc_x != 0 || acc_y != 0 || acc_wheel != 0))
            begin
                sx = clamp_step(acc_x);
                sy = clamp_step(acc_y);
                sw = clamp_step(acc_wheel);
                acc_x     -= sx;
                acc_y     -= sy;
                acc_wheel -= sw;
                n++;
                r = mouse_report(sx, sy, sw);
                r.last = (n == TICK_REPORT_LIMIT) ||
                         (acc_x == 0 && acc_y == 0 && acc_wheel == 0);
                pending_reports = {pending_reports, r};
            end
        end
        else if (ev.kind == KIND_REL)
        begin
            // other axes fall through untouched
            case (ev.code)
                CODE_REL_X:     acc_x     = sat_acc(acc_x, v);
                CODE_REL_Y:     acc_y     = sat_acc(acc_y, v);
                CODE_REL_WHEEL: acc_wheel = sat_acc(acc_wheel, v);
                default: ;
            endcase
        end
        else if (ev.kind == KIND_KEY)
        begin
            if (ev.code >= CODE_BTN_LEFT && ev.code <= CODE_BTN_MIDDLE)
            begin
                // only a press sets the button; release and repeat clear it
                button_state[ev.code[1:0]] = (v == 1);
                pending_reports = {pending_reports, mouse_report(0, 0, 0)};
            end
            else
            begin
                idx = modifier_index(ev.code);
                if (idx >= 0)
                begin
                    mod_state[idx] = (v >= 1);
                end
                else
                begin
                    usage = (ev.code < 10'd128) ? KEY_TO_USAGE[ev.code[6:0]] : 7'd0;
                    done  = 1'b0;
                    if (usage != 7'd0 && v == 1)
                    begin
                        // first free slot; duplicates allowed, full list drops the key
                        for (i = 0; i < SLOTS; i++)
                        begin
                            if (!done && held_keys[i] == 7'd0)
                            begin
                                held_keys[i] = usage;
                                done = 1'b1;
                            end
                        end
                    end
                    else if (usage != 7'd0 && v == 0)
                    begin
                        // remove first match, close the gap
                        for (i = 0; i < SLOTS; i++)
                        begin
                            if (done)
                                held_keys[i - 1] = held_keys[i];
                            else if (held_keys[i] == usage)
                                done = 1'b1;
                        end
                        if (done)
                            held_keys[SLOTS - 1] = 7'd0;
                    end
                end
                r.id      = REPORT_KBD;
                r.buttons = '0;
                r.dx      = '0;
                r.dy      = '0;
                r.dw      = '0;
                r.mods    = mod_state;
                r.slots   = '0;
                for (i = 0; i < SLOTS; i++)
                    r.slots[8 * i +: 8] = {1'b0, held_keys[i]};
                r.last    = 1'b1;
                pending_reports = {pending_reports, r};
            end
        end
    endtask

    // Phase follows progress: sender light/receiver heavy, then swapped, then none
    function automatic int idle_pct(input bit receiver);
        int phase;
        phase = (total_events > 0) ? (events_accepted * 3) / total_events : 0;
        case (phase)
            0:       return receiver ? 74 : 10;
            1:       return receiver ? 10 : 74;
            default: return 0;
        endcase
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // Driver: retire the accepted transfer, then present the next one or idle.
    // A presented transfer holds until accepted.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (event_valid && !event_stall)
            begin
                apply_event(in_flight);
                events_accepted++;
            end
            if (!event_valid || !event_stall)
            begin
                if (queued_events.size() > 0 &&
                    !(queued_events[0].hold && pending_reports.size() > 0) &&
                    $urandom_range(99) >= idle_pct(1'b0))
                begin
                    in_flight = queued_events.pop_front();
                    event_valid <= 1'b1;
                    operation   <= in_flight.op;
                    event_kind  <= in_flight.kind;
                    event_code  <= in_flight.code;
                    event_value <= in_flight.value;
                end
                else
                begin
                    event_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each accepted report against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (report_valid && !report_stall)
            begin
                if (pending_reports.size() == 0)
                begin
                    errors++;
                    $display("%0t ns: unexpected report, expected none, actual id %0d slots %0h",
                             $time, report_id, key_slots);
                end
                else
                begin
                    want_report = pending_reports.pop_front();
                    check_field("report_id",     64'(want_report.id),      64'(report_id));
                    check_field("button_mask",   64'(want_report.buttons), 64'(button_mask));
                    check_field("move_x",        64'(want_report.dx),      64'(move_x[7:0]));
                    check_field("move_y",        64'(want_report.dy),      64'(move_y[7:0]));
                    check_field("move_wheel",    64'(want_report.dw),      64'(move_wheel[7:0]));
                    check_field("modifier_mask", 64'(want_report.mods),    64'(modifier_mask));
                    check_field("key_slots",     want_report.slots,        key_slots);
                    check_field("last",          64'(want_report.last),    64'(last));
                end
            end
            report_stall <= ($urandom_range(99) < idle_pct(1'b1));
        end
    end

    task automatic queue_event(input logic op, input logic [4:0] kind, input logic [9:0] code,
                               input logic [31:0] value, input bit hold);
        input_event_t ev;
        ev.op    = op;
        ev.kind  = kind;
        ev.code  = code;
        ev.value = value;
        ev.hold  = hold;
        queued_events = {queued_events, ev};
    endtask

    // Stimulus, end of test
    initial
    begin : stimulus
        int          pick;
        int          k;
        logic [4:0]  kind;
        logic [9:0]  code;
        logic [31:0] value;

        for (k = 0; k < SLOTS; k++)
            held_keys[k] = 7'd0;
        mod_state    = '0;
        button_state = '0;
        acc_x        = 0;
        acc_y        = 0;
        acc_wheel    = 0;

        // Directed: keys, duplicates, modifiers via press and repeat
        queue_event(OP_EVENT, KIND_KEY, KEY_A, 32'd1, 1'b0);
        queue_event(OP_EVENT, KIND_KEY, KEY_A, 32'd1, 1'b0);
        queue_event(OP_EVENT, KIND_KEY, KEY_LSHIFT, 32'd1, 1'b0);
        queue_event(OP_EVENT, KIND_KEY, KEY_RMETA, 32'd2, 1'b0);
        queue_event(OP_EVENT, KIND_KEY, KEY_LSHIFT, 32'd0, 1'b0);
        // buttons: press, repeat clears, release
        queue_event(OP_EVENT, KIND_KEY, CODE_BTN_LEFT, 32'd1, 1'b0);
        queue_event(OP_EVENT, KIND_KEY, CODE_BTN_RIGHT, 32'd2, 1'b0);
        queue_event(OP_EVENT, KIND_KEY, CODE_BTN_MIDDLE, 32'd1, 1'b0);
        queue_event(OP_EVENT, KIND_KEY, CODE_BTN_LEFT, 32'd0, 1'b0);
        // codes with no usage still report
        queue_event(OP_EVENT, KIND_KEY, KEY_UNMAPPED, 32'd1, 1'b0);
        queue_event(OP_EVENT, KIND_KEY, CODE_TOP, 32'd1, 1'b0);
        // fill the list, then one press too many
        for (code = KEY_1; code <= KEY_6; code++)
            queue_event(OP_EVENT, KIND_KEY, code, 32'd1, 1'b0);
        queue_event(OP_EVENT, KIND_KEY, KEY_Q, 32'd1, 1'b0);
        // release from the middle, release of an absent key, repeat on a key
        queue_event(OP_EVENT, KIND_KEY, KEY_2, 32'd0, 1'b0);
        queue_event(OP_EVENT, KIND_KEY, KEY_2, 32'd0, 1'b0);
        queue_event(OP_EVENT, KIND_KEY, KEY_A, 32'd2, 1'b0);
        // motion at both extremes, ignored axis and kinds
        queue_event(OP_EVENT, KIND_REL, CODE_REL_X, 32'h7fff_ffff, 1'b0);
        queue_event(OP_EVENT, KIND_REL, CODE_REL_Y, 32'h8000_0000, 1'b0);
        queue_event(OP_EVENT, KIND_REL, CODE_REL_WHEEL, -32'sd5, 1'b0);
        queue_event(OP_EVENT, KIND_REL, CODE_REL_Z, 32'd100, 1'b0);
        queue_event(OP_EVENT, KIND_NONE, KEY_A, 32'd1, 1'b0);
        queue_event(OP_EVENT, KIND_TOP, CODE_REL_X, 32'd1, 1'b0);
        // full drain run, then a tick with nothing left
        queue_event(OP_TICK, KIND_NONE, '0, '0, 1'b1);
        queue_event(OP_TICK, KIND_TOP, CODE_TOP, 32'hffff_ffff, 1'b0);

        // Random: mostly well-formed traffic, some noise
        while (queued_events.size() < TARGET_EVENTS - 1)
        begin
            pick    = $urandom_range(99);
            kind    = KIND_KEY;
            code    = '0;
            value   = '0;
            if (pick < 35)
            begin
                // small key set so the list fills and drains
                code = ($urandom_range(9) == 0) ? 10'($urandom_range(767))
                                                : 10'($urandom_range(KEY_1, KEY_0));
                k = $urandom_range(99);
                value = (k < 55) ? 32'd1 : (k < 90) ? 32'd0 : (k < 95) ? 32'd2 : $urandom;
            end
            else if (pick < 45)
            begin
                code = MOD_KEYS[$urandom_range(7)];
                k = $urandom_range(9);
                value = (k < 4) ? 32'd1 : (k < 8) ? 32'd0 : (k < 9) ? 32'd2 : $urandom;
            end
            else if (pick < 55)
            begin
                code = 10'($urandom_range(CODE_BTN_LEFT, CODE_BTN_MIDDLE));
                k = $urandom_range(9);
                value = (k < 5) ? 32'd1 : (k < 8) ? 32'd0 : (k < 9) ? 32'd2 : $urandom;
            end
            else if (pick < 80)
            begin
                kind = KIND_REL;
                k = $urandom_range(9);
                code = (k < 4) ? CODE_REL_X : (k < 7) ? CODE_REL_Y :
                       (k < 9) ? CODE_REL_WHEEL : 10'($urandom_range(767));
                value = ($urandom_range(99) < 8) ? $urandom
                                                 : 32'($signed($urandom_range(600)) - 300);
            end
            else if (pick < 92)
            begin
                queue_event(OP_TICK, 5'($urandom_range(31)), 10'($urandom_range(767)),
                            $urandom, ($urandom_range(99) < 5));
                continue;
            end
            else
            begin
                kind  = 5'($urandom_range(31));
                code  = 10'($urandom_range(767));
                value = $urandom;
            end
            queue_event(OP_EVENT, kind, code, value, ($urandom_range(99) < 3));
        end
        // drain whatever motion is left
        queue_event(OP_TICK, KIND_NONE, '0, '0, 1'b0);
        total_events = queued_events.size();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (events_accepted < total_events)
            @(posedge clk);
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (errors == 0 && pending_reports.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> filelist.f
rtl/ievhid_pkg.sv
rtl/ievhid_axis_unit.sv
rtl/input_event_to_hid_report.sv
test/tb_input_event_to_hid_report.sv
